// ===== rtl/ara_pkg.sv =====
// Package for the address range allocator: payload structs, codes and the
// per-cell link types. No dependencies.
package ara_pkg;

    typedef enum logic [1:0] {
        FUNC_RESERVE_FIXED = 2'd0,
        FUNC_RESERVE_ANY   = 2'd1,
        FUNC_RELEASE       = 2'd2,
        FUNC_QUERY         = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_SPACE  = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_BAD_SIZE  = 3'd4
    } status_t;

    localparam int unsigned REG_DEFAULT_BASE   = 0;
    localparam int unsigned REG_LOWEST_ADDRESS = 1;
    localparam int unsigned REG_END_LIMIT      = 2;
    localparam int unsigned REG_GRANULE_LOG2   = 3;
    localparam int unsigned CFG_IDX_BITS       = 2;
    localparam int unsigned CFG_DATA_BITS      = 48;
    localparam int unsigned FIELD_BITS         = 48;
    localparam int unsigned KIND_BITS          = 3;
    localparam int unsigned GRAN_BITS          = 5;
    localparam logic [GRAN_BITS-1:0] GRAN_MIN  = 5'd12;
    localparam logic [GRAN_BITS-1:0] GRAN_MAX  = 5'd30;

    typedef struct packed {
        logic [1:0]            func;
        logic [FIELD_BITS-1:0] address;
        logic [FIELD_BITS-1:0] size;
        logic [KIND_BITS-1:0]  region_kind;
    } req_t;

    typedef struct packed {
        logic [2:0]            status;
        logic [FIELD_BITS-1:0] base;
        logic [FIELD_BITS-1:0] length;
        logic [KIND_BITS-1:0]  kind;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_RESULT
    } state_t;

    // Table-wide command that every cell applies in the same cycle.
    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_ROTATE,
        CMD_INSERT,
        CMD_REMOVE
    } cell_cmd_t;

endpackage

// ===== rtl/ara_cell.sv =====
// One slot of the range table. A row of these forms a rotating ring; the
// head cell is examined by the controller. Uses ara_pkg.
module ara_cell
    import ara_pkg::*;
#(
    parameter int unsigned ADDR_BITS = 48
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cell_cmd_t            cmd,
    input  logic                 sel_here,
    input  logic                 sel_after,
    input  logic [ADDR_BITS-1:0] ins_base,
    input  logic [ADDR_BITS-1:0] ins_len,
    input  logic [KIND_BITS-1:0] ins_kind,
    input  logic                 prv_valid,
    input  logic [ADDR_BITS-1:0] prv_base,
    input  logic [ADDR_BITS-1:0] prv_len,
    input  logic [KIND_BITS-1:0] prv_kind,
    input  logic                 nxt_valid,
    input  logic [ADDR_BITS-1:0] nxt_base,
    input  logic [ADDR_BITS-1:0] nxt_len,
    input  logic [KIND_BITS-1:0] nxt_kind,
    output logic                 valid,
    output logic [ADDR_BITS-1:0] base,
    output logic [ADDR_BITS-1:0] len,
    output logic [KIND_BITS-1:0] kind
);

    logic                 valid_reg, valid_next;
    logic [ADDR_BITS-1:0] base_reg, base_next;
    logic [ADDR_BITS-1:0] len_reg, len_next;
    logic [KIND_BITS-1:0] kind_reg, kind_next;

    always_comb
    begin
        valid_next = valid_reg;
        base_next  = base_reg;
        len_next   = len_reg;
        kind_next  = kind_reg;
        case (cmd)
            CMD_ROTATE:
            begin
                valid_next = nxt_valid;
                base_next  = nxt_base;
                len_next   = nxt_len;
                kind_next  = nxt_kind;
            end
            CMD_INSERT:
            begin
                // open a hole at the insert point, push later slots up
                if (sel_here)
                begin
                    valid_next = 1'b1;
                    base_next  = ins_base;
                    len_next   = ins_len;
                    kind_next  = ins_kind;
                end
                else if (sel_after)
                begin
                    valid_next = prv_valid;
                    base_next  = prv_base;
                    len_next   = prv_len;
                    kind_next  = prv_kind;
                end
            end
            CMD_REMOVE:
            begin
                if (sel_here || sel_after)
                begin
                    valid_next = nxt_valid;
                    base_next  = nxt_base;
                    len_next   = nxt_len;
                    kind_next  = nxt_kind;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        len_reg  <= len_next;
        kind_reg <= kind_next;
    end

    assign valid = valid_reg;
    assign base  = base_reg;
    assign len   = len_reg;
    assign kind  = kind_reg;

endmodule

// ===== rtl/ara_ctrl.sv =====
// Request sequencer: walks the table one slot a cycle and decides the
// result. Uses ara_pkg.
module ara_ctrl
    import ara_pkg::*;
#(
    parameter int unsigned ADDR_BITS = 48,
    parameter int unsigned IDX_BITS  = 6
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  req_t                 req,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rsp_t                 rsp,
    input  logic [ADDR_BITS-1:0] cfg_default,
    input  logic [ADDR_BITS-1:0] cfg_low,
    input  logic [ADDR_BITS-1:0] cfg_end,
    input  logic [GRAN_BITS-1:0] cfg_gran,
    input  logic [IDX_BITS:0]    used,
    input  logic                 full,
    input  logic                 cur_valid,
    input  logic [ADDR_BITS-1:0] cur_base,
    input  logic [ADDR_BITS-1:0] cur_len,
    input  logic [KIND_BITS-1:0] cur_kind,
    output cell_cmd_t            cmd,
    output logic [IDX_BITS-1:0]  pos,
    output logic [ADDR_BITS-1:0] ins_base,
    output logic [ADDR_BITS-1:0] ins_len,
    output logic [KIND_BITS-1:0] ins_kind
);

    localparam int unsigned DEPTH = 1 << IDX_BITS;
    localparam int unsigned XB    = ADDR_BITS + 1;

    state_t               state_reg, state_next;
    logic [1:0]           func_reg, func_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [ADDR_BITS-1:0] size_reg, size_next;
    logic [KIND_BITS-1:0] rkind_reg, rkind_next;
    logic [XB-1:0]        start_reg, start_next;
    logic [IDX_BITS:0]    step_reg, step_next;
    logic [IDX_BITS:0]    pos_reg, pos_next;
    logic                 found_reg, found_next;
    logic [IDX_BITS:0]    iter_reg, iter_next;
    rsp_t                 rsp_reg, rsp_next;
    logic                 do_ins_reg, do_ins_next;
    logic                 do_rem_reg, do_rem_next;

    logic [XB-1:0]        amask, gmask, c_end, r_end, r_end_al, start0_al;
    logic [ADDR_BITS-1:0] lim, high, cand;
    logic [XB-1:0]        f_end;
    logic                 win_ok;
    logic [GRAN_BITS-1:0] g;

    always_comb
    begin
        g = cfg_gran < GRAN_MIN ? GRAN_MIN : (cfg_gran > GRAN_MAX ? GRAN_MAX : cfg_gran);
        amask = (XB'(1) << g) - XB'(1);
        gmask = ~amask;
        lim   = cfg_end;
        high  = lim - ADDR_BITS'(1);
        win_ok = (lim != '0) && (cfg_low <= high);
        cand  = (req.address != '0) ? req.address : cfg_default;
        if (cand < cfg_low || cand > high)
            cand = cfg_low;
        start0_al = ({1'b0, cand} + amask) & gmask;
        c_end  = start_reg + {1'b0, size_reg};
        r_end  = {1'b0, cur_base} + {1'b0, cur_len};
        r_end_al = (r_end + amask) & gmask;
        f_end  = {1'b0, addr_reg} + {1'b0, size_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_SCAN;
            S_SCAN:   if (step_reg == used || found_reg) state_next = S_SHIFT;
            S_SHIFT:  if (step_reg[IDX_BITS-1:0] == '0)
                          state_next = S_RESULT;
            S_RESULT: if (out_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Datapath sequencing. SCAN rotates the ring until a match or through every
    // used slot, so the head cell shows slot step_reg; SHIFT completes the
    // rotation back to slot 0, then applies the insert or remove.
    always_comb
    begin
        func_next   = func_reg;
        addr_next   = addr_reg;
        size_next   = size_reg;
        rkind_next  = rkind_reg;
        start_next  = start_reg;
        step_next   = step_reg;
        pos_next    = pos_reg;
        found_next  = found_reg;
        iter_next   = iter_reg;
        rsp_next    = rsp_reg;
        do_ins_next = do_ins_reg;
        do_rem_next = do_rem_reg;
        cmd = CMD_HOLD;
        case (state_reg)
            S_IDLE:
            begin
                func_next  = req.func;
                addr_next  = req.address;
                size_next  = req.size;
                rkind_next = req.region_kind;
                start_next = start0_al;
                step_next  = '0;
                pos_next   = used;
                found_next = 1'b0;
                iter_next  = '0;
                do_ins_next = 1'b0;
                do_rem_next = 1'b0;
                rsp_next   = '0;
                rsp_next.status = ST_OK;
                if (in_valid)
                begin
                    if (req.func == FUNC_RESERVE_FIXED || req.func == FUNC_RESERVE_ANY)
                    begin
                        if (req.size == '0)
                        begin
                            rsp_next.status = ST_BAD_SIZE; found_next = 1'b1;
                        end
                        else if (req.func == FUNC_RESERVE_FIXED &&
                                 req.size - ADDR_BITS'(1) > ~req.address)
                        begin
                            rsp_next.status = ST_BAD_SIZE; found_next = 1'b1;
                        end
                        else if (full)
                        begin
                            rsp_next.status = ST_FULL; found_next = 1'b1;
                        end
                        else if (req.func == FUNC_RESERVE_ANY &&
                                 (!win_ok || start0_al[ADDR_BITS] ||
                                  start0_al[ADDR_BITS-1:0] > high))
                        begin
                            rsp_next.status = ST_NO_SPACE; found_next = 1'b1;
                        end
                        else
                            do_ins_next = 1'b1;
                    end
                    else if (req.func == FUNC_RELEASE)
                        rsp_next.status = ST_NOT_FOUND;
                end
            end
            S_SCAN:
            begin
                if (!(step_reg == used || found_reg))
                begin
                    cmd = CMD_ROTATE;
                    step_next = step_reg + 1'b1;
                    case (func_reg)
                        FUNC_RESERVE_FIXED:
                        begin
                            if (cur_base < f_end[ADDR_BITS-1:0] || f_end[ADDR_BITS])
                            begin
                                if (r_end > {1'b0, addr_reg})
                                begin
                                    found_next = 1'b1;
                                    do_ins_next = 1'b0;
                                    rsp_next.status = ST_NO_SPACE;
                                end
                            end
                            if (!found_next && cur_base < addr_reg)
                                pos_next = pos_reg;
                            if (!found_next && cur_base >= addr_reg && pos_reg == used)
                                pos_next = step_reg;
                        end
                        FUNC_RESERVE_ANY:
                        begin
                            // ranges ending at or before start are skipped
                            if (r_end > start_reg)
                            begin
                                if (c_end > {1'b0, lim})
                                begin
                                    found_next = 1'b1; do_ins_next = 1'b0;
                                    rsp_next.status = ST_NO_SPACE;
                                end
                                else if ({1'b0, cur_base} >= c_end)
                                begin
                                    found_next = 1'b1;
                                    pos_next = step_reg;
                                end
                                else
                                begin
                                    iter_next = iter_reg + 1'b1;
                                    start_next = r_end_al;
                                    if (r_end_al[ADDR_BITS] ||
                                        r_end_al[ADDR_BITS-1:0] > high ||
                                        iter_reg == (IDX_BITS+1)'(DEPTH))
                                    begin
                                        found_next = 1'b1; do_ins_next = 1'b0;
                                        rsp_next.status = ST_NO_SPACE;
                                    end
                                end
                            end
                        end
                        FUNC_RELEASE:
                        begin
                            if (cur_base == addr_reg)
                            begin
                                found_next = 1'b1;
                                do_rem_next = 1'b1;
                                pos_next = step_reg;
                                rsp_next.status = ST_OK;
                            end
                        end
                        default:
                        begin
                            if (cur_valid && cur_base <= addr_reg &&
                                addr_reg - cur_base < cur_len)
                            begin
                                found_next = 1'b1;
                                rsp_next.base = cur_base;
                                rsp_next.length = cur_len;
                                rsp_next.kind = cur_kind;
                            end
                        end
                    endcase
                end
                else
                begin
                    if (func_reg == FUNC_RESERVE_ANY && do_ins_reg && !found_reg)
                    begin
                        if (c_end > {1'b0, lim})
                        begin
                            do_ins_next = 1'b0;
                            rsp_next.status = ST_NO_SPACE;
                        end
                    end
                end
            end
            S_SHIFT:
            begin
                if (step_reg[IDX_BITS-1:0] != '0)
                begin
                    cmd = CMD_ROTATE;
                    step_next = step_reg + 1'b1;
                end
                else if (do_ins_reg)
                begin
                    cmd = CMD_INSERT;
                    rsp_next.base = (func_reg == FUNC_RESERVE_FIXED) ? addr_reg
                                    : start_reg[ADDR_BITS-1:0];
                end
                else if (do_rem_reg)
                    cmd = CMD_REMOVE;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            do_ins_reg <= 1'b0;
            do_rem_reg <= 1'b0;
            found_reg  <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            do_ins_reg <= do_ins_next;
            do_rem_reg <= do_rem_next;
            found_reg  <= found_next;
            step_reg   <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg  <= func_next;
        addr_reg  <= addr_next;
        size_reg  <= size_next;
        rkind_reg <= rkind_next;
        start_reg <= start_next;
        pos_reg   <= pos_next;
        iter_reg  <= iter_next;
        rsp_reg   <= rsp_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_RESULT);
    assign rsp       = rsp_reg;
    assign pos       = pos_reg[IDX_BITS-1:0];
    assign ins_base  = (func_reg == FUNC_RESERVE_FIXED) ? addr_reg : start_reg[ADDR_BITS-1:0];
    assign ins_len   = size_reg;
    assign ins_kind  = rkind_reg;

endmodule

// ===== rtl/address_range_allocator.sv =====
// Address range allocator top level: config registers, a ring of table
// cells and the sequencer. Uses ara_pkg, ara_cell and ara_ctrl.
//
// Items are handled one at a time: the cell ring is rotated one slot per
// cycle through a full turn, DEPTH being TABLE_DEPTH rounded up to a power
// of two, so every used slot passes the head cell, where the sequencer
// examines it; then the insert or remove is applied, the result is presented
// and only after it is taken is the next item accepted. An empty table, or a
// request settled before the walk (zero size, range past the address space,
// full table, empty search window), needs no rotation. A held result stalls
// the input. No clearing pass follows reset.
module address_range_allocator
    import ara_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  req_t                     in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output rsp_t                     out_data,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    localparam int unsigned ADDR_BITS = FIELD_BITS;
    localparam int unsigned IDX_BITS  = $clog2(TABLE_DEPTH);
    localparam int unsigned DEPTH     = 1 << IDX_BITS;

    logic [ADDR_BITS-1:0] dflt_reg, low_reg, end_reg;
    logic [GRAN_BITS-1:0] gran_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dflt_reg <= ADDR_BITS'(65536);
            low_reg  <= ADDR_BITS'(65536);
            end_reg  <= ADDR_BITS'(48'h7FFF_FFFF_0000);
            gran_reg <= GRAN_BITS'(16);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDX_BITS'(REG_DEFAULT_BASE):   dflt_reg <= ADDR_BITS'(cfg_wdata);
                CFG_IDX_BITS'(REG_LOWEST_ADDRESS): low_reg  <= ADDR_BITS'(cfg_wdata);
                CFG_IDX_BITS'(REG_END_LIMIT):      end_reg  <= ADDR_BITS'(cfg_wdata);
                CFG_IDX_BITS'(REG_GRANULE_LOG2):   gran_reg <= cfg_wdata[GRAN_BITS-1:0];
                default:                           ;
            endcase
        end
    end

    logic                 c_valid [DEPTH];
    logic [ADDR_BITS-1:0] c_base  [DEPTH];
    logic [ADDR_BITS-1:0] c_len   [DEPTH];
    logic [KIND_BITS-1:0] c_kind  [DEPTH];
    cell_cmd_t            cmd;
    logic [IDX_BITS-1:0]  pos;
    logic [ADDR_BITS-1:0] ins_base, ins_len;
    logic [KIND_BITS-1:0] ins_kind;
    logic [IDX_BITS:0]    used_reg, used_next;

    always_comb
    begin
        used_next = used_reg;
        if (cmd == CMD_INSERT)
            used_next = used_reg + 1'b1;
        else if (cmd == CMD_REMOVE)
            used_next = used_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            used_reg <= '0;
        else
            used_reg <= used_next;
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam int unsigned P = (i + DEPTH - 1) % DEPTH;
        localparam int unsigned N = (i + 1) % DEPTH;
        ara_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .sel_here  (pos == IDX_BITS'(i)),
            .sel_after (IDX_BITS'(i) > pos),
            .ins_base  (ins_base),
            .ins_len   (ins_len),
            .ins_kind  (ins_kind),
            .prv_valid (c_valid[P] && (i != 0)),
            .prv_base  (c_base[P]),
            .prv_len   (c_len[P]),
            .prv_kind  (c_kind[P]),
            .nxt_valid ((cmd == CMD_ROTATE) ? c_valid[N] : (c_valid[N] && (i != DEPTH-1))),
            .nxt_base  (c_base[N]),
            .nxt_len   (c_len[N]),
            .nxt_kind  (c_kind[N]),
            .valid     (c_valid[i]),
            .base      (c_base[i]),
            .len       (c_len[i]),
            .kind      (c_kind[i])
        );
    end

    ara_ctrl #(.ADDR_BITS(ADDR_BITS), .IDX_BITS(IDX_BITS)) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req        (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .rsp        (out_data),
        .cfg_default(dflt_reg),
        .cfg_low    (low_reg),
        .cfg_end    (end_reg),
        .cfg_gran   (gran_reg),
        .used       (used_reg),
        .full       (used_reg == (IDX_BITS+1)'(TABLE_DEPTH)),
        .cur_valid  (c_valid[0]),
        .cur_base   (c_base[0]),
        .cur_len    (c_len[0]),
        .cur_kind   (c_kind[0]),
        .cmd        (cmd),
        .pos        (pos),
        .ins_base   (ins_base),
        .ins_len    (ins_len),
        .ins_kind   (ins_kind)
    );

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= (IDX_BITS+1)'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output open together");

    a_ins_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == CMD_INSERT |-> used_reg < (IDX_BITS+1)'(TABLE_DEPTH))
        else $error("insert into full table");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for address_range_allocator: a scoreboard class
// keeps its own region table and predicts every result. Depends on ara_pkg.
module testbench;
    import ara_pkg::*;

    localparam int DEPTH = 64;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 140;
    localparam logic [47:0] ADDR_MAX = 48'hFFFF_FFFF_FFFF;

    class alloc_scoreboard;
        logic [47:0] dflt_base;
        logic [47:0] low_addr;
        logic [47:0] end_lim;
        logic [4:0]  gran;
        logic [47:0] bases [DEPTH];
        logic [47:0] lens [DEPTH];
        logic [2:0]  kinds [DEPTH];
        int          count;
        rsp_t        expected_q [$];
        int          errors;
        int          checked;
        int          status_seen [8];

        function new();
            dflt_base = 48'h1_0000;
            low_addr  = 48'h1_0000;
            end_lim   = 48'h7FFF_FFFF_0000;
            gran      = 5'd16;
            count     = 0;
            errors    = 0;
            checked   = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void set_reg(int idx, logic [47:0] v);
            case (idx)
                REG_DEFAULT_BASE:   dflt_base = v;
                REG_LOWEST_ADDRESS: low_addr = v;
                REG_END_LIMIT:      end_lim = v;
                REG_GRANULE_LOG2:   gran = v[4:0];
                default: ;
            endcase
        endfunction

        function longint unsigned round_up(longint unsigned v, longint unsigned a);
            return (v + a - 1) & ~(a - 1);
        endfunction

        // First-fit walk over the sorted table, aligned to the granule.
        function bit find_gap(longint unsigned hint, longint unsigned sz,
                              output longint unsigned found);
            longint unsigned g, align, lim, low, high, cand, start, stop, rend;
            bit conflict;
            found = 0;
            g = (gran < 12) ? 12 : ((gran > 30) ? 30 : gran);
            align = 64'd1 << g;
            lim = end_lim;
            low = low_addr;
            if (lim == 0) return 0;
            high = lim - 1;
            if (low > high) return 0;
            cand = (hint != 0) ? hint : dflt_base;
            if (cand < low || cand > high) cand = low;
            start = round_up(cand, align);
            for (int iter = 0; iter <= DEPTH && start <= high; iter++) begin
                stop = start + sz;
                conflict = 0;
                if (stop > lim) return 0;
                for (int i = 0; i < count; i++) begin
                    rend = bases[i] + lens[i];
                    if (rend <= start) continue;
                    if (bases[i] >= stop) break;
                    conflict = 1;
                    start = round_up(rend, align);
                    break;
                end
                if (!conflict) begin
                    found = start;
                    return 1;
                end
            end
            return 0;
        endfunction

        function void add_region(logic [47:0] b, logic [47:0] l, logic [2:0] k);
            int pos;
            pos = 0;
            while (pos < count && bases[pos] < b) pos++;
            for (int i = count; i > pos; i--) begin
                bases[i] = bases[i-1];
                lens[i]  = lens[i-1];
                kinds[i] = kinds[i-1];
            end
            bases[pos] = b;
            lens[pos]  = l;
            kinds[pos] = k;
            count++;
        endfunction

        function rsp_t predict(req_t r);
            rsp_t o;
            longint unsigned a, sz, found;
            bit hit;
            o = '0;
            a = r.address;
            sz = r.size;
            case (func_t'(r.func))
                FUNC_RESERVE_FIXED, FUNC_RESERVE_ANY: begin
                    if (sz == 0)
                        o.status = ST_BAD_SIZE;
                    else if (r.func == FUNC_RESERVE_FIXED && sz - 1 > ADDR_MAX - a)
                        o.status = ST_BAD_SIZE;
                    else if (count >= DEPTH)
                        o.status = ST_FULL;
                    else if (r.func == FUNC_RESERVE_FIXED) begin
                        hit = 0;
                        for (int i = 0; i < count; i++)
                            if (bases[i] < a + sz && bases[i] + lens[i] > a) hit = 1;
                        if (hit)
                            o.status = ST_NO_SPACE;
                        else begin
                            add_region(r.address, r.size, r.region_kind);
                            o.base = r.address;
                        end
                    end else if (find_gap(a, sz, found)) begin
                        add_region(found[47:0], r.size, r.region_kind);
                        o.base = found[47:0];
                    end else
                        o.status = ST_NO_SPACE;
                end
                FUNC_RELEASE: begin
                    o.status = ST_NOT_FOUND;
                    for (int i = 0; i < count; i++) begin
                        if (bases[i] == r.address) begin
                            for (int j = i; j + 1 < count; j++) begin
                                bases[j] = bases[j+1];
                                lens[j]  = lens[j+1];
                                kinds[j] = kinds[j+1];
                            end
                            count--;
                            o.status = ST_OK;
                            break;
                        end
                    end
                end
                default: begin
                    for (int i = 0; i < count; i++) begin
                        if (bases[i] <= r.address && a - bases[i] < lens[i]) begin
                            o.base = bases[i];
                            o.length = lens[i];
                            o.kind = kinds[i];
                            break;
                        end
                    end
                end
            endcase
            return o;
        endfunction

        function void note_request(req_t r);
            expected_q = {expected_q, predict(r)};
        endfunction

        function void check_result(rsp_t got);
            rsp_t exp_r;
            if (expected_q.size() == 0) begin
                $error("unexpected result item status=%0d base=%h", got.status, got.base);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            checked++;
            status_seen[exp_r.status]++;
            if (got.status !== exp_r.status) begin
                $error("status: expected %0d, got %0d", exp_r.status, got.status);
                errors++;
            end
            if (got.base !== exp_r.base) begin
                $error("base: expected %h, got %h", exp_r.base, got.base);
                errors++;
            end
            if (got.length !== exp_r.length) begin
                $error("length: expected %h, got %h", exp_r.length, got.length);
                errors++;
            end
            if (got.kind !== exp_r.kind) begin
                $error("kind: expected %0d, got %0d", exp_r.kind, got.kind);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    req_t in_data;
    logic out_valid;
    logic out_ready;
    rsp_t out_data;
    logic cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_wdata;

    alloc_scoreboard sb = new();
    bit quiet;
    int idle_cycles;
    int sent;

    address_range_allocator uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off, none at the end.
    initial begin
        int cyc;
        bit held;
        cyc = 0;
        held = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            if (quiet) begin
                out_ready <= 1'b1;
                @(posedge clk);
            end else if (!held && cyc > 3000) begin
                held = 1;
                out_ready <= 1'b0;
                repeat (700) @(posedge clk);
            end else begin
                int n;
                n = $urandom_range(1, 15);
                out_ready <= ($urandom_range(0, 2) != 0);
                repeat (n) @(posedge clk);
                cyc += n;
            end
        end
    end

    function automatic logic [47:0] rand48();
        logic [63:0] t;
        t = {$urandom(), $urandom()};
        return t[47:0];
    endfunction

    task automatic send_item(logic [1:0] f, logic [47:0] a, logic [47:0] s, logic [2:0] k);
        req_t r;
        r.func = f;
        r.address = a;
        r.size = s;
        r.region_kind = k;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        do @(posedge clk); while (!in_ready);
        sb.note_request(r);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(int idx, logic [47:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx[CFG_IDX_BITS-1:0];
        cfg_wdata <= v;
        @(posedge clk);
        sb.set_reg(idx, v);
    endtask

    task automatic set_window(logic [47:0] d, logic [47:0] lo, logic [47:0] e, logic [4:0] g);
        write_reg(REG_DEFAULT_BASE, d);
        write_reg(REG_LOWEST_ADDRESS, lo);
        write_reg(REG_END_LIMIT, e);
        write_reg(REG_GRANULE_LOG2, {43'd0, g});
        cfg_we <= 1'b0;
    endtask

    function automatic logic [47:0] pick_size();
        int p;
        int g;
        g = (sb.gran < 12) ? 12 : ((sb.gran > 30) ? 30 : sb.gran);
        p = $urandom_range(0, 99);
        if (p < 5) return 48'd0;
        if (p < 80) return 48'(longint'($urandom_range(1, 4 << (g - 10))) << 10) - 48'($urandom_range(0, 1));
        return rand48() >> $urandom_range(0, 47);
    endfunction

    function automatic logic [47:0] pick_window_addr();
        longint unsigned span;
        int p;
        p = $urandom_range(0, 3);
        if (p == 0) return 48'd0;
        if (p == 3 || sb.end_lim <= sb.low_addr) return rand48();
        span = sb.end_lim - sb.low_addr;
        return sb.low_addr + 48'({$urandom(), $urandom()} % span);
    endfunction

    function automatic logic [47:0] pick_region_addr(bit inside_hit);
        int i;
        longint unsigned off;
        if (sb.count == 0 || $urandom_range(0, 4) == 0) return rand48();
        i = $urandom_range(0, sb.count - 1);
        if (!inside_hit) return sb.bases[i];
        off = {$urandom(), $urandom()} % (longint'(sb.lens[i]) + 1);
        return sb.bases[i] + 48'(off);
    endfunction

    // Mix of operations; reserve_pct steers how full the table gets.
    task automatic random_items(int n, int reserve_pct);
        int p;
        repeat (n) begin
            p = $urandom_range(0, 99);
            if (p < reserve_pct * 3 / 4)
                send_item(FUNC_RESERVE_ANY, pick_window_addr(), pick_size(), 3'($urandom));
            else if (p < reserve_pct)
                send_item(FUNC_RESERVE_FIXED,
                          ($urandom_range(0, 1) != 0) ? pick_region_addr(1) : rand48(),
                          pick_size(), 3'($urandom));
            else if (p < reserve_pct + (100 - reserve_pct) / 2)
                send_item(FUNC_RELEASE, pick_region_addr(0), rand48(), 3'($urandom));
            else
                send_item(FUNC_QUERY, pick_region_addr(1), rand48(), 3'($urandom));
        end
    endtask

    initial begin
        quiet = 0;
        sent = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners under the reset settings.
        send_item(FUNC_RESERVE_ANY, 48'd0, 48'd1, 3'd7);
        send_item(FUNC_RESERVE_FIXED, 48'd0, ADDR_MAX, 3'd1);
        send_item(FUNC_RESERVE_FIXED, ADDR_MAX, 48'd1, 3'd2);
        send_item(FUNC_RESERVE_FIXED, ADDR_MAX, 48'd2, 3'd2);
        send_item(FUNC_RESERVE_FIXED, 48'h1000, 48'd0, 3'd3);
        send_item(FUNC_RESERVE_ANY, 48'h1000, 48'd0, 3'd3);
        send_item(FUNC_RESERVE_FIXED, 48'h1000, 48'h100, 3'd0);
        send_item(FUNC_QUERY, 48'h1050, 48'd0, 3'd0);
        send_item(FUNC_QUERY, 48'h5, 48'd0, 3'd0);
        send_item(FUNC_QUERY, ADDR_MAX, 48'd0, 3'd0);
        send_item(FUNC_RELEASE, 48'h1000, 48'd5, 3'd0);
        send_item(FUNC_RELEASE, 48'h1000, 48'd5, 3'd0);
        send_item(FUNC_RESERVE_FIXED, 48'h1_0000, 48'h10, 3'd4);
        send_item(FUNC_RESERVE_ANY, ADDR_MAX, 48'h1_0000, 3'd5);
        send_item(FUNC_RESERVE_ANY, 48'h2_0000, 48'h7FFF_FFFF_0000, 3'd6);
        send_item(FUNC_RESERVE_ANY, 48'h1_0001, 48'h1234, 3'd1);
        send_item(FUNC_QUERY, 48'h1_0000, 48'd0, 3'd0);
        send_item(FUNC_RELEASE, ADDR_MAX, ADDR_MAX, 3'd7);
        send_item(FUNC_QUERY, 48'h3_0000, 48'd0, 3'd0);
        random_items(260, 70);

        drain();
        set_window(48'd0, 48'd0, 48'h400_0000, 5'd12);
        random_items(260, 60);
        drain();
        set_window(ADDR_MAX, 48'h1000_0000, ADDR_MAX, 5'd30);
        random_items(240, 75);
        drain();
        set_window(48'h20_0000, 48'h10_0000, 48'h40_0000, 5'd0);
        random_items(240, 55);
        drain();
        set_window(48'd0, 48'h5000, 48'd0, 5'd31);
        random_items(120, 50);
        drain();
        set_window(48'h1_0000, 48'h8000_0000, 48'h8000_0000, 5'd20);
        random_items(120, 50);
        drain();
        quiet = 1;
        set_window(48'h1_0000, 48'h1_0000, 48'h7FFF_FFFF_0000, 5'd16);
        random_items(440, 50);

        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d requests over seven window settings; %0d results checked.",
                 sent, sb.checked);
        $display("Status counts ok/no-space/not-found/full/bad-size: %0d %0d %0d %0d %0d",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
                 sb.status_seen[3], sb.status_seen[4]);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ara_pkg.sv
rtl/ara_cell.sv
rtl/ara_ctrl.sv
rtl/address_range_allocator.sv
tb/testbench.sv
